>>> design/bctc_pkg.sv
// Shared types and constants of the block cache tag controller.
// No dependencies; every other file of the block uses this package.
package bctc_pkg;

  localparam int DEF_SLOTS          = 8;
  localparam int DEF_BLOCK_TAG_BITS = 32;

  localparam int OP_W       = 2;
  localparam int FILE_W     = 4;
  localparam int BLOCK_W    = 32;
  localparam int SLOT_OUT_W = 3;
  localparam int SEED_W     = 16;

  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [SEED_W-1:0] LFSR_RESET = 16'h0001;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  // One decoded word as it travels from the front end to the back end.
  typedef struct packed {
    logic                is_access;
    logic                is_write;
    logic                is_close;
    logic [FILE_W-1:0]   file;
    logic [BLOCK_W-1:0]  block;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_MUL,
    ST_VICTIM,
    ST_SCAN
  } state_t;

endpackage

>>> design/bctc_cmd_if.sv
// Command channel of the block cache tag controller: valid/ready plus one word.
// Depends on bctc_pkg for field widths.
interface bctc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bctc_pkg::OP_W-1:0]     operation;
  logic [bctc_pkg::FILE_W-1:0]   file_number;
  logic [bctc_pkg::BLOCK_W-1:0]  block_number;

  modport source(output valid, output operation, output file_number, output block_number,
                 input ready);
  modport sink(input valid, input operation, input file_number, input block_number,
               output ready);
endinterface

>>> design/bctc_res_if.sv
// Result channel of the block cache tag controller: valid/ready plus one word.
// Depends on bctc_pkg for field widths.
interface bctc_res_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [bctc_pkg::SLOT_OUT_W-1:0]  slot;
  logic                             fill_needed;
  logic                             writeback_valid;
  logic [bctc_pkg::FILE_W-1:0]      writeback_file;
  logic [bctc_pkg::BLOCK_W-1:0]     writeback_block;
  logic                             last;

  modport source(output valid, output hit, output slot, output fill_needed,
                 output writeback_valid, output writeback_file, output writeback_block,
                 output last, input ready);
  modport sink(input valid, input hit, input slot, input fill_needed,
               input writeback_valid, input writeback_file, input writeback_block,
               input last, output ready);
endinterface

>>> design/block_cache_tag_controller_core.sv
// Block cache tag controller: fully associative write-back tag store with random
// replacement. A command word enters a decode register, waits in a two-word queue,
// and is carried out by the back end, which holds every tag and drives a result
// register, so commands are taken while a result waits. A read or write that hits,
// or misses into a free slot, gives its result from the access state; a miss that
// needs a victim steps the LFSR and forms the reciprocal product, then the remainder,
// then the result. Flush and close fetch the command, then give one result word per
// dirty block of the file (at least one word), the last one flagged.
// The user must write the victim seed register with cfg_write/cfg_data only while
// idle; the block itself does not enforce it. Zero loads one. Depends on bctc_pkg,
// bctc_cmd_if, bctc_res_if and the three units.
module block_cache_tag_controller_core #(
  parameter int SLOTS          = bctc_pkg::DEF_SLOTS,
  parameter int BLOCK_TAG_BITS = bctc_pkg::DEF_BLOCK_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bctc_pkg::SEED_W-1:0]   cfg_data,
  bctc_cmd_if.sink                      cmd,
  bctc_res_if.source                    res
);
  import bctc_pkg::*;

  logic  q_push;
  cmd_t  q_entry;
  logic  q_full;
  logic  q_pop;
  cmd_t  q_data;
  logic  q_empty;

  bctc_front #(
    .BLOCK_TAG_BITS(BLOCK_TAG_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_full  (q_full)
  );

  bctc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  bctc_back #(
    .SLOTS         (SLOTS),
    .BLOCK_TAG_BITS(BLOCK_TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res       (res)
  );

endmodule

>>> design/bctc_front.sv
// Front end: accepts command words, decodes the operation, masks the block number.
// Depends on bctc_pkg and bctc_cmd_if; feeds bctc_queue.
module bctc_front #(
  parameter int BLOCK_TAG_BITS = bctc_pkg::DEF_BLOCK_TAG_BITS
) (
  input  logic            clk,
  input  logic            rst,
  bctc_cmd_if.sink        cmd,
  output logic            q_push,
  output bctc_pkg::cmd_t  q_entry,
  input  logic            q_full
);
  import bctc_pkg::*;

  localparam logic [BLOCK_W-1:0] TAG_MASK = (BLOCK_TAG_BITS >= BLOCK_W) ? '1 :
    BLOCK_W'((64'd1 << BLOCK_TAG_BITS) - 64'd1);

  logic  held;
  cmd_t  entry;
  cmd_t  decoded;

  always_comb begin
    decoded           = '0;
    decoded.file      = cmd.file_number;
    decoded.block     = cmd.block_number & TAG_MASK;
    unique case (op_t'(cmd.operation))
      OP_READ:  decoded.is_access = 1'b1;
      OP_WRITE: begin
        decoded.is_access = 1'b1;
        decoded.is_write  = 1'b1;
      end
      OP_FLUSH: decoded.is_close = 1'b0;
      OP_CLOSE: decoded.is_close = 1'b1;
      default:  decoded.is_close = 1'b0;
    endcase
  end

  assign q_push    = held && !q_full;
  assign q_entry   = entry;
  assign cmd.ready = !held || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      entry <= decoded;
    end
  end

endmodule

>>> design/bctc_queue.sv
// Short FIFO of decoded words between the front end and the back end.
// Depends on bctc_pkg for the word type and the depth.
module bctc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bctc_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output bctc_pkg::cmd_t  pop_data,
  output logic            empty
);
  import bctc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              words [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = words[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      words[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/bctc_back.sv
// Back end: tag store, victim LFSR with modulo unit, flush/close scan, result register.
// Depends on bctc_pkg and bctc_res_if; drains bctc_queue.
module bctc_back #(
  parameter int SLOTS          = bctc_pkg::DEF_SLOTS,
  parameter int BLOCK_TAG_BITS = bctc_pkg::DEF_BLOCK_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bctc_pkg::SEED_W-1:0]   cfg_data,
  input  logic                          q_empty,
  input  bctc_pkg::cmd_t                q_data,
  output logic                          q_pop,
  bctc_res_if.source                    res
);
  import bctc_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PROD_W = SEED_W + 32;
  // floor(2^32 / SLOTS): quotient estimate is at most one short
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

  state_t state;
  state_t state_next;

  cmd_t                       cur;
  logic [SLOTS-1:0]           slot_valid;
  logic [SLOTS-1:0]           slot_dirty;
  logic [FILE_W-1:0]          slot_file_tag  [SLOTS];
  logic [BLOCK_TAG_BITS-1:0]  slot_block_tag [SLOTS];

  logic [SEED_W-1:0]  lfsr;
  logic [SEED_W-1:0]  lfsr_adv;
  logic [PROD_W-1:0]  prod;
  logic [SLOT_W-1:0]  victim;
  logic [SEED_W-1:0]  quot;
  logic [SEED_W-1:0]  rem_raw;
  logic [SEED_W-1:0]  rem_fix;

  logic [BLOCK_TAG_BITS-1:0] cur_tag;
  logic [SLOTS-1:0] file_vec;
  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] pend_vec;
  logic [SLOTS-1:0] pend_low;
  logic [SLOTS-1:0] pend_rest;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] pend_idx;
  logic any_hit;
  logic any_free;
  logic any_pend;

  logic out_free;
  logic emit;
  logic emit_hit;
  logic [SLOT_W-1:0] emit_slot;
  logic emit_fill;
  logic emit_wbv;
  logic [FILE_W-1:0] emit_wbf;
  logic [BLOCK_TAG_BITS-1:0] emit_wbb;
  logic emit_last;

  function automatic logic [SLOTS-1:0] lowest(input logic [SLOTS-1:0] v);
    return v & (~v + SLOTS'(1));
  endfunction

  function automatic logic [SLOT_W-1:0] onehot_idx(input logic [SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (v[i]) begin
        r = r | SLOT_W'(i);
      end
    end
    return r;
  endfunction

  assign cur_tag = BLOCK_TAG_BITS'(cur.block);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      file_vec[i]  = slot_valid[i] && (slot_file_tag[i] == cur.file);
      match_vec[i] = file_vec[i] && (slot_block_tag[i] == cur_tag);
      pend_vec[i]  = file_vec[i] && slot_dirty[i];
    end
  end

  assign any_hit   = |match_vec;
  assign any_free  = ~&slot_valid;
  assign any_pend  = |pend_vec;
  assign hit_idx   = onehot_idx(lowest(match_vec));
  assign free_idx  = onehot_idx(lowest(~slot_valid));
  assign pend_low  = lowest(pend_vec);
  assign pend_rest = pend_vec & ~pend_low;
  assign pend_idx  = onehot_idx(pend_low);

  // Galois step: shift right, fold the taps in when a one drops out
  assign lfsr_adv = {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);

  // remainder of lfsr by SLOTS from the registered reciprocal product
  assign quot    = prod[PROD_W-1:32];
  assign rem_raw = lfsr - SEED_W'(quot * SEED_W'(SLOTS));
  assign rem_fix = (rem_raw >= SEED_W'(SLOTS)) ? rem_raw - SEED_W'(SLOTS) : rem_raw;

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_hit   = 1'b0;
    emit_slot  = '0;
    emit_fill  = 1'b0;
    emit_wbv   = 1'b0;
    emit_wbf   = '0;
    emit_wbb   = '0;
    emit_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_data.is_access ? ST_ACCESS : ST_SCAN;
        end
      end
      ST_ACCESS: begin
        if (any_hit) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_hit   = 1'b1;
            emit_slot  = hit_idx;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (any_free) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_slot  = free_idx;
            emit_fill  = 1'b1;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_VICTIM;
      end
      ST_VICTIM: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_slot  = victim;
          emit_fill  = 1'b1;
          emit_wbv   = slot_dirty[victim];
          emit_wbf   = slot_dirty[victim] ? slot_file_tag[victim] : '0;
          emit_wbb   = slot_dirty[victim] ? slot_block_tag[victim] : '0;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          emit = 1'b1;
          if (any_pend) begin
            emit_slot = pend_idx;
            emit_wbv  = 1'b1;
            emit_wbf  = slot_file_tag[pend_idx];
            emit_wbb  = slot_block_tag[pend_idx];
            emit_last = (pend_rest == '0);
          end else begin
            emit_last = 1'b1;
          end
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_RESET;
    end else if (cfg_write) begin
      lfsr <= (cfg_data == '0) ? LFSR_RESET : cfg_data;
    end else if (state == ST_ACCESS && !any_hit && !any_free) begin
      lfsr <= lfsr_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACCESS) begin
      prod <= PROD_W'(lfsr_adv) * PROD_W'(RECIP);
    end
    if (state == ST_MUL) begin
      victim <= SLOT_W'(rem_fix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
    end else if (emit) begin
      if (state == ST_ACCESS && any_hit) begin
        slot_dirty[hit_idx] <= slot_dirty[hit_idx] | cur.is_write;
      end
      if (emit_fill) begin
        slot_valid[emit_slot] <= 1'b1;
        slot_dirty[emit_slot] <= cur.is_write;
      end
      if (state == ST_SCAN) begin
        // clean the listed block; on the final word a close drops the whole file
        if (emit_last && cur.is_close) begin
          slot_valid <= slot_valid & ~file_vec;
        end
        slot_dirty <= slot_dirty & ~pend_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && emit_fill) begin
      slot_file_tag[emit_slot]  <= cur.file;
      slot_block_tag[emit_slot] <= cur_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.hit             <= emit_hit;
      res.slot            <= SLOT_OUT_W'(emit_slot);
      res.fill_needed     <= emit_fill;
      res.writeback_valid <= emit_wbv;
      res.writeback_file  <= emit_wbf;
      res.writeback_block <= BLOCK_W'(emit_wbb);
      res.last            <= emit_last;
    end
  end

endmodule
